FILE: src/signed_int_to_decimal_ascii_unit_macros.svh
// Assertion macros shared by the RTL files that check their own logic.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SITD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SITD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sitd_pkg.sv
package sitd_pkg;

	// Field widths
	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 8;
	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int IDX_W      = $clog2(NUM_DIGITS);
	localparam int CNT_W      = $clog2(VALUE_W);

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// ASCII codes
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Classified word: sign and unsigned magnitude
	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} sitd_item_t;

	// Converted word: sign and packed BCD digits, digit 0 least significant
	typedef struct packed {
		logic             neg;
		logic [BCD_W-1:0] bcd;
	} sitd_digits_t;

	// Converter sequencer states
	typedef enum logic [1:0] {
		CONV_IDLE,
		CONV_SHIFT,
		CONV_DONE
	} sitd_conv_state_t;

endpackage

FILE: src/sitd_front.sv
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitd_front import sitd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      q_valid,
	input  logic                      q_ready,
	output sitd_item_t                q_item
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	sitd_item_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_QW-1:0]       count_q;
	logic [VALUE_W-1:0]      raw;
	sitd_item_t              item;
	logic                    push;
	logic                    pop;

	// Classify: sign bit and magnitude in unsigned arithmetic
	always_comb begin
		raw      = value;
		item.neg = raw[VALUE_W-1];
		item.mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
	end

	assign in_ready = (count_q != CNT_QW'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SITD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_QW'(QUEUE_DEPTH), "queue overfilled")

endmodule

FILE: src/sitd_conv.sv
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitd_conv import sitd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	output logic         q_ready,
	input  sitd_item_t   q_item,
	output logic         d_valid,
	input  logic         d_ready,
	output sitd_digits_t d_word
);

	sitd_conv_state_t   state_q;
	sitd_conv_state_t   state_d;
	logic [VALUE_W-1:0] mag_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic               neg_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               load;
	logic               step;
	logic               last_step;

	assign last_step = (cnt_q == CNT_W'(VALUE_W - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CONV_IDLE: begin
				if (q_valid) state_d = CONV_SHIFT;
			end
			CONV_SHIFT: begin
				if (last_step) state_d = CONV_DONE;
			end
			CONV_DONE: begin
				if (d_ready) state_d = CONV_IDLE;
			end
			default: state_d = CONV_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		q_ready = 1'b0;
		d_valid = 1'b0;
		step    = 1'b0;
		unique case (state_q)
			CONV_IDLE:  q_ready = 1'b1;
			CONV_SHIFT: step    = 1'b1;
			CONV_DONE:  d_valid = 1'b1;
			default: ;
		endcase
	end

	assign load = q_valid && q_ready;

	// Add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q <= '0;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Shift-add-3 datapath, one magnitude bit per cycle, MSB first
	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= q_item.mag;
			neg_q <= q_item.neg;
			bcd_q <= '0;
		end else if (step) begin
			mag_q <= {mag_q[VALUE_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_W-1]};
		end
	end

	assign d_word.neg = neg_q;
	assign d_word.bcd = bcd_q;

	`SITD_ASSERT_NXT(a_done_after_shift, state_q == CONV_SHIFT && last_step, state_q == CONV_DONE, "converter missed end of shift")

endmodule

FILE: src/sitd_emit.sv
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module sitd_emit import sitd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              d_valid,
	output logic              d_ready,
	input  sitd_digits_t      d_word,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] char_code,
	output logic              last
);

	logic [BCD_W-1:0]  bcd_q;
	logic [IDX_W-1:0]  idx_q;
	logic              neg_pend_q;
	logic              busy_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic [IDX_W-1:0]  msd;
	logic [3:0]        digit;
	logic              advance;
	logic              load;

	// Most significant nonzero digit; zero value keeps digit 0
	always_comb begin
		msd = '0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (d_word.bcd[4*i +: 4] != 4'd0) msd = IDX_W'(i);
		end
	end

	assign digit   = bcd_q[4*idx_q +: 4];
	assign advance = !out_valid_q || out_ready;
	assign d_ready = !busy_q;
	assign load    = d_valid && d_ready;

	// Digit walker control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			neg_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q     <= 1'b1;
				neg_pend_q <= d_word.neg;
			end else if (busy_q && advance) begin
				if (neg_pend_q) begin
					neg_pend_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	// Digit walker data and output word register
	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= d_word.bcd;
			idx_q <= msd;
		end else if (busy_q && advance) begin
			if (neg_pend_q) begin
				char_q <= ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= ASCII_ZERO + {4'b0000, digit};
				last_q <= (idx_q == '0);
				idx_q  <= idx_q - 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	`SITD_ASSERT_IMP(a_last_is_digit, out_valid_q && last_q, char_q >= ASCII_ZERO && char_q <= ASCII_NINE, "last word is not a digit")
	`SITD_ASSERT_IMP(a_idx_range, busy_q, idx_q <= IDX_W'(NUM_DIGITS - 1), "digit index out of range")

endmodule

FILE: src/signed_int_to_decimal_ascii_unit.sv
// channel | signals                          | word
// --------+----------------------------------+-------------------------------
// in      | in_valid, in_ready, value        | 32-bit two's-complement integer
// out     | out_valid, out_ready, char_code, | one ASCII character, last marks
//         | last                             | the end of the number's text
//
// A word passes through the shift-add-3 converter as load, one shift step per
// magnitude bit and hand-off; that unit sets the sustained rate. The emitter
// streams one character per cycle while out_ready is high and overlaps the next conversion.
// The input queue holds QUEUE_DEPTH classified words, so in_ready stays high
// while the converter is busy until the queue fills.
// Reset (arst_n low) empties the queue and idles converter and emitter.
// A stalled out_ready holds the current character; the converter then waits.
module signed_int_to_decimal_ascii_unit import sitd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [CHAR_W-1:0]         char_code,
	output logic                      last
);

	logic         q_valid;
	logic         q_ready;
	sitd_item_t   q_item;
	logic         d_valid;
	logic         d_ready;
	sitd_digits_t d_word;

	// Front: accept, split sign and magnitude, queue
	sitd_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	// Back: binary to BCD
	sitd_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_item  (q_item),
		.d_valid (d_valid),
		.d_ready (d_ready),
		.d_word  (d_word)
	);

	// Back: character stream
	sitd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.d_valid   (d_valid),
		.d_ready   (d_ready),
		.d_word    (d_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

endmodule
